// ===== rtl/core/fat_block_chain_manager_macros.svh =====
// ----------------------------------------------------------------------------
// fat_block_chain_manager_macros.svh
// Assertion macros shared by the block chain manager checkers.
// ----------------------------------------------------------------------------
`ifndef FAT_BLOCK_CHAIN_MANAGER_MACROS_SVH
`define FAT_BLOCK_CHAIN_MANAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBCM_ASSERT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fbcm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBCM_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fbcm assertion failed");

`endif

// ===== rtl/core/fbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fbcm_pkg
// Shared codes and request/result types of the block chain manager.
// ----------------------------------------------------------------------------
package fbcm_pkg;

	localparam int OP_W   = 2;
	localparam int BLK_W  = 7;
	localparam int ST_W   = 2;
	localparam int KIND_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_EXTEND = 2'd1;
	localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_END  = 2'd2;

	// table entry kinds
	localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LINK = 2'd2;

	// classified request as it sits in the queue
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [BLK_W-1:0] block;
		logic             oob;
	} cmd_t;

	// result toward the ports
	typedef struct packed {
		logic             done;
		logic [BLK_W-1:0] result_block;
		logic [ST_W-1:0]  status;
	} result_t;

endpackage

// ===== rtl/core/fbcm_ram.sv =====
// ----------------------------------------------------------------------------
// fbcm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/fbcm_front.sv =====
// ----------------------------------------------------------------------------
// fbcm_front
// Request intake: handshake, range check and classification into the queue.
// ----------------------------------------------------------------------------
module fbcm_front #(
	parameter int BLOCKS = 128
) (
	input  logic                         start,
	input  logic [fbcm_pkg::OP_W-1:0]    op,
	input  logic [fbcm_pkg::BLK_W-1:0]   block,
	input  logic                         q_full,
	input  logic                         clearing,
	output logic                         busy,
	output logic                         push,
	output fbcm_pkg::cmd_t               cmd
);

	localparam int CMPW = $clog2(BLOCKS) + fbcm_pkg::BLK_W + 1;
	localparam logic [CMPW-1:0] BLK_LIMIT = CMPW'(BLOCKS);

	logic oob;

	// hold off requests while the table is swept or the queue is full
	assign busy = q_full | clearing;
	assign push = start & ~busy;

	// allocate ignores the block; everything else checks it against the table size
	assign oob = (op != fbcm_pkg::OP_ALLOC) && (CMPW'(block) >= BLK_LIMIT);

	assign cmd.op    = op;
	assign cmd.block = block;
	assign cmd.oob   = oob;

endmodule

// ===== rtl/core/fbcm_queue.sv =====
// ----------------------------------------------------------------------------
// fbcm_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module fbcm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fbcm_pkg::cmd_t push_cmd,
	input  logic           pop,
	output fbcm_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);

	fbcm_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/core/fbcm_back.sv =====
// ----------------------------------------------------------------------------
// fbcm_back
// Request execution: table sweep after reset, free-block scan, chain walk.
// ----------------------------------------------------------------------------
module fbcm_back #(
	parameter int BLOCKS = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  fbcm_pkg::cmd_t    q_head,
	output logic              q_pop,
	output logic              clearing,
	output fbcm_pkg::result_t res
);

	localparam int IDXW = $clog2(BLOCKS);
	localparam int EW   = fbcm_pkg::KIND_W + IDXW;
	localparam logic [IDXW-1:0] LAST      = IDXW'(BLOCKS - 1);
	localparam logic [IDXW:0]   SCAN_END  = (IDXW+1)'(BLOCKS);
	localparam logic [EW-1:0]   ENTRY_END = {fbcm_pkg::KIND_END, {IDXW{1'b0}}};

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_MARK  = 4'd4;
	localparam logic [3:0] S_LINK  = 4'd5;
	localparam logic [3:0] S_NCHK  = 4'd6;
	localparam logic [3:0] S_FRD   = 4'd7;
	localparam logic [3:0] S_FCHK  = 4'd8;

	logic [3:0]                   state_q, state_d;
	logic [IDXW-1:0]              clr_q;
	logic [IDXW:0]                scan_q;
	logic                         chk_vld_s1;
	logic [IDXW-1:0]              chk_addr_s1;
	logic [IDXW-1:0]              nb_q, nb_d;
	logic [IDXW-1:0]              cur_q, cur_d;
	fbcm_pkg::cmd_t               cmd_q;
	logic                         done_q;
	logic [fbcm_pkg::BLK_W-1:0]   res_blk_q;
	logic [fbcm_pkg::ST_W-1:0]    st_q;

	logic                         we, re;
	logic [IDXW-1:0]              waddr, raddr;
	logic [EW-1:0]                wdata, rdata;
	logic [fbcm_pkg::KIND_W-1:0]  rd_kind;
	logic [IDXW-1:0]              rd_link;
	logic [IDXW-1:0]              idx;
	logic                         issue;
	logic                         fin;
	logic [fbcm_pkg::BLK_W-1:0]   fin_blk;
	logic [fbcm_pkg::ST_W-1:0]    fin_st;

	fbcm_ram #(
		.WIDTH (EW),
		.DEPTH (BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_kind  = rdata[EW-1:IDXW];
	assign rd_link  = rdata[IDXW-1:0];
	assign idx      = IDXW'(cmd_q.block);
	assign clearing = (state_q == S_CLEAR);

	// sequencer: table port, queue pop and result selection
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		re      = 1'b0;
		raddr   = '0;
		q_pop   = 1'b0;
		issue   = 1'b0;
		fin     = 1'b0;
		fin_blk = '0;
		fin_st  = fbcm_pkg::ST_OK;
		nb_d    = nb_q;
		cur_d   = cur_q;
		unique case (state_q)
			S_CLEAR: begin
				// one entry per cycle; the root starts as end of chain
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == '0) ? ENTRY_END : '0;
				if (clr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (cmd_q.oob) begin
					fin     = 1'b1;
					fin_st  = (cmd_q.op == fbcm_pkg::OP_FREE) ? fbcm_pkg::ST_OK
						: fbcm_pkg::ST_END;
					state_d = S_IDLE;
				end else begin
					unique case (cmd_q.op)
						fbcm_pkg::OP_ALLOC,
						fbcm_pkg::OP_EXTEND: state_d = S_SCAN;
						fbcm_pkg::OP_NEXT: begin
							re      = 1'b1;
							raddr   = idx;
							state_d = S_NCHK;
						end
						default: begin
							cur_d   = idx;
							state_d = S_FRD;
						end
					endcase
				end
			end
			S_SCAN: begin
				// reads run one ahead of the check of the returned entry
				if (chk_vld_s1 && rd_kind == fbcm_pkg::KIND_FREE) begin
					nb_d    = chk_addr_s1;
					state_d = S_MARK;
				end else if (chk_vld_s1 && chk_addr_s1 == LAST) begin
					fin     = 1'b1;
					fin_st  = fbcm_pkg::ST_FULL;
					state_d = S_IDLE;
				end else begin
					issue = (scan_q < SCAN_END);
					re    = issue;
					raddr = scan_q[IDXW-1:0];
				end
			end
			S_MARK: begin
				we    = 1'b1;
				waddr = nb_q;
				wdata = ENTRY_END;
				if (cmd_q.op == fbcm_pkg::OP_EXTEND) begin
					state_d = S_LINK;
				end else begin
					fin     = 1'b1;
					fin_blk = fbcm_pkg::BLK_W'(nb_q);
					state_d = S_IDLE;
				end
			end
			S_LINK: begin
				// a self link overwrites the end mark just written
				we      = 1'b1;
				waddr   = idx;
				wdata   = {fbcm_pkg::KIND_LINK, nb_q};
				fin     = 1'b1;
				fin_blk = fbcm_pkg::BLK_W'(nb_q);
				state_d = S_IDLE;
			end
			S_NCHK: begin
				fin = 1'b1;
				if (rd_kind == fbcm_pkg::KIND_LINK) begin
					fin_blk = fbcm_pkg::BLK_W'(rd_link);
				end else begin
					fin_st = fbcm_pkg::ST_END;
				end
				state_d = S_IDLE;
			end
			S_FRD: begin
				re      = 1'b1;
				raddr   = cur_q;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				// stop on a free entry, else clear it and follow a link
				if (rd_kind == fbcm_pkg::KIND_FREE) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					we    = 1'b1;
					waddr = cur_q;
					wdata = '0;
					if (rd_kind == fbcm_pkg::KIND_LINK) begin
						cur_d   = rd_link;
						state_d = S_FRD;
					end else begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			scan_q     <= '0;
			chk_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= issue;
			done_q     <= fin;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IDXW'(1);
			end
			// the scan starts above the root
			if (state_q == S_DISP) begin
				scan_q <= (IDXW+1)'(1);
			end else if (issue) begin
				scan_q <= scan_q + (IDXW+1)'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		chk_addr_s1 <= scan_q[IDXW-1:0];
		nb_q        <= nb_d;
		cur_q       <= cur_d;
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (fin) begin
			res_blk_q <= fin_blk;
			st_q      <= fin_st;
		end
	end

	assign res.done         = done_q;
	assign res.result_block = res_blk_q;
	assign res.status       = st_q;

endmodule

// ===== rtl/core/fat_block_chain_manager.sv =====
// ----------------------------------------------------------------------------
// fat_block_chain_manager
// File allocation table keeper: allocate, extend, next and free chain requests.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------
//  request   | start / busy       | op, block
//  result    | done (1-cycle)     | result_block, status
//
//  After reset the table is swept once, one entry per cycle, and busy stays high
//  until the sweep is done. A request waits in a two-entry queue, then the back
//  end runs it against the simple dual-port table RAM: next reads one entry,
//  allocate and extend scan from entry 1 up for a free entry and mark it (extend
//  then links the block to it), and free chain reads and clears each entry in turn.
//  Results are strobed on done for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module fat_block_chain_manager #(
	parameter int BLOCKS = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [fbcm_pkg::OP_W-1:0]  op,
	input  logic [fbcm_pkg::BLK_W-1:0] block,
	output logic                       done,
	output logic [fbcm_pkg::BLK_W-1:0] result_block,
	output logic [fbcm_pkg::ST_W-1:0]  status
);

	logic              push;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	logic              clearing;
	fbcm_pkg::cmd_t    push_cmd;
	fbcm_pkg::cmd_t    q_head;
	fbcm_pkg::result_t res;

	// intake and classification
	fbcm_front #(
		.BLOCKS (BLOCKS)
	) u_front (
		.start    (start),
		.op       (op),
		.block    (block),
		.q_full   (q_full),
		.clearing (clearing),
		.busy     (busy),
		.push     (push),
		.cmd      (push_cmd)
	);

	// request queue
	fbcm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// execution against the table
	fbcm_back #(
		.BLOCKS (BLOCKS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.res      (res)
	);

	assign done         = res.done;
	assign result_block = res.result_block;
	assign status       = res.status;

endmodule

// ===== rtl/core/fbcm_checker.sv =====
// ----------------------------------------------------------------------------
// fbcm_checker
// Port-level checks of the block chain manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "fat_block_chain_manager_macros.svh"

module fbcm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [fbcm_pkg::OP_W-1:0]  op,
	input logic [fbcm_pkg::BLK_W-1:0] block,
	input logic                       done,
	input logic [fbcm_pkg::BLK_W-1:0] result_block,
	input logic [fbcm_pkg::ST_W-1:0]  status
);

	// the table sweep holds off requests right after reset
	`FBCM_ASSERT(a_busy_after_reset, clk, arst_n, !$past(arst_n), busy && !done)

	// every result passes through an idle and a dispatch cycle
	`FBCM_ASSERT_NXT(a_done_spaced, clk, arst_n, done, !done)

	// a failed request never names a block
	`FBCM_ASSERT(a_fail_zero, clk, arst_n, done && status != fbcm_pkg::ST_OK,
		result_block == '0)

	// a strobed result carries known values
	`FBCM_ASSERT(a_res_known, clk, arst_n, done, !$isunknown({result_block, status}))

endmodule

bind fat_block_chain_manager fbcm_checker u_fbcm_checker (.*);

// ===== verif/fat_block_chain_manager_tb.sv =====
// ----------------------------------------------------------------------------
// fat_block_chain_manager_tb
// Drives allocate, extend, next and free chain requests into the block chain
// manager and tracks its own copy of the allocation table. Every request that
// is taken predicts one result, and each result strobed on done is compared
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module fat_block_chain_manager_tb;
	import fbcm_pkg::*;

	localparam int BLOCKS      = 128;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_ITEMS  = 400;

	typedef struct packed {
		logic [BLK_W-1:0] result_block;
		logic [ST_W-1:0]  status;
	} outcome_t;

	// Table tracker: shadow allocation table plus the results still owed
	class fat_chain_tracker;
		logic [KIND_W-1:0] entry_kind [BLOCKS];
		logic [BLK_W-1:0]  entry_link [BLOCKS];
		outcome_t          pending_results [$];
		int                errors;

		function new();
			for (int i = 0; i < BLOCKS; i++) begin
				entry_kind[i] = KIND_FREE;
				entry_link[i] = '0;
			end
			entry_kind[0] = KIND_END;
			errors = 0;
		endfunction

		// lowest free entry from 1 up becomes end of chain
		function bit claim_lowest_free(output logic [BLK_W-1:0] idx);
			idx = '0;
			for (int i = 1; i < BLOCKS; i++) begin
				if (entry_kind[i] == KIND_FREE) begin
					entry_kind[i] = KIND_END;
					entry_link[i] = '0;
					idx = i[BLK_W-1:0];
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function bit table_full();
			for (int i = 1; i < BLOCKS; i++)
				if (entry_kind[i] == KIND_FREE)
					return 1'b0;
			return 1'b1;
		endfunction

		// random block, biased toward ones that are in use
		function logic [BLK_W-1:0] pick_used();
			int idx;
			idx = 0;
			for (int t = 0; t < 8; t++) begin
				idx = $urandom_range(0, BLOCKS - 1);
				if (entry_kind[idx] != KIND_FREE)
					return idx[BLK_W-1:0];
			end
			return idx[BLK_W-1:0];
		endfunction

		// apply one accepted request to the table and queue its result
		function void log_request(logic [OP_W-1:0] req_op, logic [BLK_W-1:0] blk);
			outcome_t          o;
			logic [BLK_W-1:0]  nb;
			logic [KIND_W-1:0] k;
			logic [BLK_W-1:0]  nxt;
			int                cur;
			o.result_block = '0;
			o.status       = ST_OK;
			case (req_op)
				OP_ALLOC: begin
					if (claim_lowest_free(nb))
						o.result_block = nb;
					else
						o.status = ST_FULL;
				end
				OP_EXTEND: begin
					if (int'(blk) >= BLOCKS) begin
						o.status = ST_END;
					end else if (claim_lowest_free(nb)) begin
						// previous successor of blk, if any, is orphaned
						entry_kind[blk] = KIND_LINK;
						entry_link[blk] = nb;
						o.result_block  = nb;
					end else begin
						o.status = ST_FULL;
					end
				end
				OP_NEXT: begin
					if (int'(blk) < BLOCKS && entry_kind[blk] == KIND_LINK)
						o.result_block = entry_link[blk];
					else
						o.status = ST_END;
				end
				default: begin
					// walk stops after an end entry or on a free one
					cur = blk;
					for (int s = 0; s <= BLOCKS; s++) begin
						if (cur >= BLOCKS)
							break;
						k = entry_kind[cur];
						if (k == KIND_FREE)
							break;
						nxt = entry_link[cur];
						entry_kind[cur] = KIND_FREE;
						entry_link[cur] = '0;
						if (k != KIND_LINK)
							break;
						cur = nxt;
					end
				end
			endcase
			pending_results.push_back(o);
		endfunction

		function void check_result(logic [BLK_W-1:0] rb, logic [ST_W-1:0] st);
			outcome_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result block %0d status %0d", $time, rb, st);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (rb !== want.result_block) begin
				$display("%0t: result_block mismatch expected %0d actual %0d",
					$time, want.result_block, rb);
				errors++;
			end
			if (st !== want.status) begin
				$display("%0t: status mismatch expected %0d actual %0d",
					$time, want.status, st);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [OP_W-1:0]  op;
	logic [BLK_W-1:0] block;
	logic             done;
	logic [BLK_W-1:0] result_block;
	logic [ST_W-1:0]  status;

	fat_chain_tracker tracker;
	int               burst_left;
	int               sent;
	int               cycles;

	fat_block_chain_manager #(
		.BLOCKS(BLOCKS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.block       (block),
		.done        (done),
		.result_block(result_block),
		.status      (status)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_result(result_block, status);
	end

	// Issue one request; returns at the edge that takes it, then maybe idles
	task automatic issue(input logic [OP_W-1:0] o, input logic [BLK_W-1:0] b);
		int gap;
		start <= 1'b1;
		op    <= o;
		block <= b;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.log_request(o, b);
		sent++;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end else begin
			burst_left--;
		end
	endtask

	// Stimulus
	initial begin
		int  kind_sel;
		int  n;
		bit  filled;
		sent       = 0;
		filled     = 1'b0;
		burst_left = $urandom_range(0, 24);
		tracker    = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		op         = OP_ALLOC;
		block      = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: root, free blocks, self link, orphaned chain, root freed
		issue(OP_NEXT, 7'd0);
		issue(OP_NEXT, 7'd127);
		issue(OP_FREE, 7'd127);
		issue(OP_ALLOC, 7'd99);
		issue(OP_EXTEND, 7'd1);
		issue(OP_NEXT, 7'd1);
		issue(OP_NEXT, 7'd2);
		issue(OP_EXTEND, 7'd5);
		issue(OP_NEXT, 7'd5);
		issue(OP_EXTEND, 7'd4);
		issue(OP_NEXT, 7'd4);
		issue(OP_FREE, 7'd4);
		issue(OP_EXTEND, 7'd1);
		issue(OP_NEXT, 7'd1);
		issue(OP_FREE, 7'd1);
		issue(OP_NEXT, 7'd2);
		issue(OP_FREE, 7'd0);
		issue(OP_NEXT, 7'd0);
		issue(OP_EXTEND, 7'd0);
		issue(OP_ALLOC, 7'd0);
		issue(OP_EXTEND, 7'd127);
		issue(OP_NEXT, 7'd127);
		issue(OP_FREE, 7'd5);
		issue(OP_FREE, 7'd127);

		// random episodes; one fill to drive-full partway through
		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (!filled && sent >= RAND_ITEMS / 2) begin
				filled = 1'b1;
				while (!tracker.table_full())
					issue(($urandom_range(0, 2) == 0) ? OP_ALLOC : OP_EXTEND,
						tracker.pick_used());
				issue(OP_ALLOC, 7'($urandom_range(0, BLOCKS - 1)));
				issue(OP_EXTEND, tracker.pick_used());
				issue(OP_NEXT, tracker.pick_used());
				issue(OP_FREE, tracker.pick_used());
				continue;
			end
			kind_sel = $urandom_range(0, 8);
			n = $urandom_range(2, 12);
			repeat (n) begin
				case (kind_sel)
					0, 1, 2, 3:
						issue(($urandom_range(0, 3) == 0) ? OP_ALLOC : OP_EXTEND,
							tracker.pick_used());
					4, 5:
						issue(OP_NEXT, ($urandom_range(0, 3) == 0)
							? 7'($urandom_range(0, BLOCKS - 1)) : tracker.pick_used());
					6:
						issue(($urandom_range(0, 1) == 0) ? OP_FREE : OP_NEXT,
							tracker.pick_used());
					7:
						issue(OP_FREE, 7'($urandom_range(0, BLOCKS - 1)));
					default:
						issue(2'($urandom_range(0, 3)), 7'($urandom_range(0, BLOCKS - 1)));
				endcase
			end
		end

		// drain
		start <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * BLOCKS + 16) @(posedge clk);
		if (tracker.pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time,
				tracker.pending_results.size());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
